// ===== src/spm_pkg.sv =====
package spm_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int COEFF_W  = 16;
    localparam int EXPO_W   = 16;
    localparam int TERM_W   = COEFF_W + EXPO_W;
    localparam int SUM_W    = COEFF_W + 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int FUNC_W     = 2;
    localparam int OUT_USER_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [TERM_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

// ===== src/spm_ram.sv =====
module spm_ram #(
    parameter int DEPTH_P = 16,
    parameter int ADDR_W  = 4,
    parameter int DATA_W  = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH_P];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/spm_ctrl.sv =====
module spm_ctrl import spm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [TERM_W-1:0]     i_term,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SUM_W-1:0]      o_sum_coeff,
    output logic [EXPO_W-1:0]     o_res_expo,
    output logic                  o_last,
    output logic                  o_empty_res,
    output logic                  o_overflow,
    output t_ram_req              o_req_a,
    output t_ram_req              o_req_b,
    input  logic [TERM_W-1:0]     i_rd_a,
    input  logic [TERM_W-1:0]     i_rd_b
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic             r_drop, n_drop;

    logic              r_out_valid;
    logic [SUM_W-1:0]  r_sum_coeff;
    logic [EXPO_W-1:0] r_res_expo;
    logic              r_last;
    logic              r_empty_res;
    logic              r_overflow;

    logic              w_accept;
    logic              w_slot;
    logic              w_emit;
    logic              w_a_valid;
    logic              w_b_valid;
    logic [EXPO_W-1:0] w_ea, w_eb;
    logic [SUM_W-1:0]  w_ca, w_cb;
    logic [CNT_W-1:0]  w_pi, w_pj;
    logic [SUM_W-1:0]  w_coeff;
    logic [EXPO_W-1:0] w_expo;
    logic              w_empty;
    logic              w_term_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == ST_RUN) && w_slot;

    assign w_a_valid = (r_i < r_cnt_a);
    assign w_b_valid = (r_j < r_cnt_b);
    assign w_ea = i_rd_a[TERM_W-1:COEFF_W];
    assign w_eb = i_rd_b[TERM_W-1:COEFF_W];
    assign w_ca = {i_rd_a[COEFF_W-1], i_rd_a[COEFF_W-1:0]};
    assign w_cb = {i_rd_b[COEFF_W-1], i_rd_b[COEFF_W-1:0]};

    // pick the head term and where each list advances to
    always_comb begin
        w_pi    = r_i;
        w_pj    = r_j;
        w_coeff = '0;
        w_expo  = '0;
        w_empty = 1'b0;
        priority if (!w_a_valid && !w_b_valid) begin
            w_empty = 1'b1;
        end else if (w_a_valid && w_b_valid && (w_ea == w_eb)) begin
            w_coeff = w_ca + w_cb;
            w_expo  = w_ea;
            w_pi    = r_i + CNT_W'(1);
            w_pj    = r_j + CNT_W'(1);
        end else if (w_a_valid && (!w_b_valid || (w_ea > w_eb))) begin
            w_coeff = w_ca;
            w_expo  = w_ea;
            w_pi    = r_i + CNT_W'(1);
        end else begin
            w_coeff = w_cb;
            w_expo  = w_eb;
            w_pj    = r_j + CNT_W'(1);
        end
    end

    assign w_term_last = w_empty || ((w_pi >= r_cnt_a) && (w_pj >= r_cnt_b));

    always_comb begin
        n_state = r_state;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_i     = r_i;
        n_j     = r_j;
        n_drop  = r_drop;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_func)
                        FUNC_LOAD_A: begin
                            if (r_cnt_a < CNT_W'(DEPTH)) begin
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        FUNC_LOAD_B: begin
                            if (r_cnt_b < CNT_W'(DEPTH)) begin
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        FUNC_RUN: begin
                            n_state = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_emit) begin
                    if (w_term_last) begin
                        n_state = ST_IDLE;
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_drop  = 1'b0;
                    end else begin
                        n_i = w_pi;
                        n_j = w_pj;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_i     <= n_i;
            r_j     <= n_j;
            r_drop  <= n_drop;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sum_coeff <= w_coeff;
            r_res_expo  <= w_expo;
            r_last      <= w_term_last;
            r_empty_res <= w_empty;
            r_overflow  <= r_drop;
        end
    end

    // Read address follows the next index, so the read register holds the heads for the current index.
    // Loads only write while idle, and a run is started by its own request after
    // the last load, so the reads that a run uses never race a write to the same entry.
    always_comb begin
        o_req_a       = '0;
        o_req_b       = '0;
        o_req_a.wdata = i_term;
        o_req_b.wdata = i_term;
        o_req_a.waddr = r_cnt_a[IDX_W-1:0];
        o_req_b.waddr = r_cnt_b[IDX_W-1:0];
        o_req_a.we    = w_accept && (i_func == FUNC_LOAD_A) && (r_cnt_a < CNT_W'(DEPTH));
        o_req_b.we    = w_accept && (i_func == FUNC_LOAD_B) && (r_cnt_b < CNT_W'(DEPTH));
        o_req_a.raddr = n_i[IDX_W-1:0];
        o_req_b.raddr = n_j[IDX_W-1:0];
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_coeff = r_sum_coeff;
    assign o_res_expo  = r_res_expo;
    assign o_last      = r_last;
    assign o_empty_res = r_empty_res;
    assign o_overflow  = r_overflow;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= r_cnt_a) && (r_j <= r_cnt_b))
        else $error("merge index ran past its list");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(DEPTH)) && (r_cnt_b <= CNT_W'(DEPTH)))
        else $error("list count above depth");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_term_last) |=>
        (r_cnt_a == '0) && (r_cnt_b == '0) && !r_drop && (r_state == ST_IDLE))
        else $error("run end did not clear the lists");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_i == '0) && (r_j == '0))
        else $error("merge index left non-zero while idle");

    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_req_a.we && !o_req_b.we)
        else $error("store written during a run");

endmodule

// ===== src/sparse_polynomial_add_merge_top.sv =====
// Channel  | Dir | tdata (low bit up)                      | tuser / tlast
// s_axis   | in  | coeff[15:0], expo[31:16]                 | tuser: func
// m_axis   | out | sum_coeff[16:0], res_expo[32:17], zeros  | tuser: empty_res, overflow
//          |     |                                          | tlast: last
// A run gives one result item a cycle while the output is not stalled: the list
// heads come from the two single-read-port stores, read at the next index, so
// the registered read already holds the heads that each item is merged from.
// Reset (synchronous, active low) empties both lists and clears the drop flag.
// A stalled output holds the merge; input is refused until the run has ended.
module sparse_polynomial_add_merge_top import spm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // coeff, expo
    input  logic [FUNC_W-1:0]     s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // sum_coeff, res_expo, zero fill
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // empty_res, overflow
    output logic                  m_axis_tlast
);

    t_ram_req          w_req_a, w_req_b;
    logic [TERM_W-1:0] w_rd_a, w_rd_b;
    logic [TERM_W-1:0] w_term;
    logic [SUM_W-1:0]  w_sum_coeff;
    logic [EXPO_W-1:0] w_res_expo;
    logic              w_empty_res;
    logic              w_overflow;

    // store words hold exponent high, coefficient low
    assign w_term = {s_axis_tdata[COEFF_W +: EXPO_W], s_axis_tdata[COEFF_W-1:0]};

    spm_ram #(
        .DEPTH_P (DEPTH),
        .ADDR_W  (IDX_W),
        .DATA_W  (TERM_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_req_a.we),
        .i_waddr (w_req_a.waddr),
        .i_wdata (w_req_a.wdata),
        .i_raddr (w_req_a.raddr),
        .o_rdata (w_rd_a)
    );

    spm_ram #(
        .DEPTH_P (DEPTH),
        .ADDR_W  (IDX_W),
        .DATA_W  (TERM_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_req_b.we),
        .i_waddr (w_req_b.waddr),
        .i_wdata (w_req_b.wdata),
        .i_raddr (w_req_b.raddr),
        .o_rdata (w_rd_b)
    );

    spm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_term      (w_term),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_sum_coeff (w_sum_coeff),
        .o_res_expo  (w_res_expo),
        .o_last      (m_axis_tlast),
        .o_empty_res (w_empty_res),
        .o_overflow  (w_overflow),
        .o_req_a     (w_req_a),
        .o_req_b     (w_req_b),
        .i_rd_a      (w_rd_a),
        .i_rd_b      (w_rd_b)
    );

    assign m_axis_tdata = {(OUT_DATA_W - SUM_W - EXPO_W)'(0), w_res_expo, w_sum_coeff};
    assign m_axis_tuser = {w_overflow, w_empty_res};

endmodule
